// ----- src/vfcm_pkg.sv -----
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared types and lookup tables for the voxel face-cull / AO mesher.
// ----------------------------------------------------------------------------
package vfcm_pkg;

    localparam int COORD_W     = 5;
    localparam int NB_W        = 27;
    localparam int COUNT_W     = 17;
    localparam int NUM_FACES   = 6;
    localparam int FACE_W      = 3;
    localparam int CORNER_W    = 2;
    localparam int AO_W        = 2;
    localparam int NB_IDX_W    = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CORNER_W-1:0] LAST_CORNER = 2'd3;

    // Block request as it travels from the front to the back.
    typedef struct packed {
        logic                 chunk_start;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [COORD_W-1:0]   z;
        logic [NB_W-1:0]      nb;
        logic [NUM_FACES-1:0] face_mask;
    } block_t;

    // One emitted vertex.
    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [FACE_W-1:0]   face;
        logic [CORNER_W-1:0] corner;
        logic [AO_W-1:0]     ao;
        logic [COUNT_W-1:0]  index;
        logic                last;
    } vertex_t;

    // Neighbor bit that makes each face visible: south, north, east, west, up, down.
    localparam logic [NB_IDX_W-1:0] FACE_BIT [0:NUM_FACES-1] =
        '{5'd14, 5'd12, 5'd22, 5'd4, 5'd16, 5'd10};

    // Cube corner offset per face corner, packed as x | y<<1 | z<<2.
    localparam logic [2:0] CORNER_POS [0:NUM_FACES-1][0:3] = '{
        '{3'd4, 3'd5, 3'd7, 3'd6},
        '{3'd1, 3'd0, 3'd2, 3'd3},
        '{3'd5, 3'd1, 3'd3, 3'd7},
        '{3'd0, 3'd4, 3'd6, 3'd2},
        '{3'd3, 3'd2, 3'd6, 3'd7},
        '{3'd0, 3'd1, 3'd5, 3'd4}
    };

    // Neighbor bits touching each face corner.
    localparam logic [NB_IDX_W-1:0] AO_BIT [0:NUM_FACES-1][0:3][0:2] = '{
        '{'{5'd5, 5'd2, 5'd11},   '{5'd11, 5'd20, 5'd23},
          '{5'd17, 5'd26, 5'd23}, '{5'd5, 5'd8, 5'd17}},
        '{'{5'd21, 5'd18, 5'd9},  '{5'd9, 5'd0, 5'd3},
          '{5'd15, 5'd6, 5'd3},   '{5'd21, 5'd24, 5'd15}},
        '{'{5'd23, 5'd20, 5'd19}, '{5'd19, 5'd18, 5'd21},
          '{5'd25, 5'd24, 5'd21}, '{5'd23, 5'd26, 5'd25}},
        '{'{5'd3, 5'd0, 5'd1},    '{5'd1, 5'd2, 5'd5},
          '{5'd7, 5'd8, 5'd5},    '{5'd3, 5'd6, 5'd7}},
        '{'{5'd25, 5'd24, 5'd15}, '{5'd15, 5'd6, 5'd7},
          '{5'd17, 5'd8, 5'd7},   '{5'd25, 5'd26, 5'd17}},
        '{'{5'd1, 5'd0, 5'd9},    '{5'd9, 5'd18, 5'd19},
          '{5'd11, 5'd20, 5'd19}, '{5'd1, 5'd2, 5'd11}}
    };

endpackage

// ----- src/voxel_face_cull_ao_mesher.sv -----
// ----------------------------------------------------------------------------
// voxel_face_cull_ao_mesher
// Culled-face voxel mesher with per-corner ambient occlusion.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one request per block of a bordered chunk. It carries
//   the block coordinates and the transparency bits of its 3x3x3
//   neighborhood in tdata, and the chunk-start and air flags in tuser.
//   Output stream (m_*): one request per vertex, four per visible face, faces
//   in the order south, north, east, west, up, down. tlast marks the final
//   vertex of a block. Air and fully enclosed blocks emit nothing.
//   Path: an accepted block is held in the front register, then written into
//   a queue slot; its vertices are built from the queue head and registered.
//   Throughput: the back end emits one vertex per cycle while m_tready is
//   high, four per visible face; hidden blocks are dropped in the front end
//   at one per cycle, and an air block with chunk start reaches the back end
//   only to clear the counter. A four-entry queue lets the front keep accepting
//   blocks while the back works through earlier ones.
//   Reset: clears the vertex counter, the queue and both valid flags.
//   Stall: when m_tready is low the vertex register holds; the queue fills
//   and then s_tready drops until the receiver resumes.
//   Index triangles are implied: 0,1,2,0,2,3 from each face's first index.
// ----------------------------------------------------------------------------
module voxel_face_cull_ao_mesher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // block_x[4:0], block_y[9:5], block_z[14:10],
                                   // neighbor_clear[41:15], zero pad[47:42]
    input  logic [1:0]  s_tuser,   // chunk_start[0], block_air[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // vertex_x[4:0], vertex_y[9:5], vertex_z[14:10],
                                   // face_code[17:15], corner_number[19:18],
                                   // ao_level[21:20], vertex_index[38:22], zero pad[39]
    output logic        m_tlast    // last_of_block
);

    logic              push_valid;
    logic              push_ready;
    vfcm_pkg::block_t  push_block;
    logic              head_valid;
    logic              head_pop;
    vfcm_pkg::block_t  head_block;
    vfcm_pkg::vertex_t vertex;

    // Classify each block and drop those with no work.
    vfcm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_chunk_start (s_tuser[0]),
        .in_air         (s_tuser[1]),
        .in_x           (s_tdata[4:0]),
        .in_y           (s_tdata[9:5]),
        .in_z           (s_tdata[14:10]),
        .in_nb          (s_tdata[41:15]),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_block     (push_block)
    );

    // Decouple block acceptance from vertex emission.
    vfcm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_block (push_block),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_block (head_block)
    );

    // Walk faces and corners, one vertex per cycle while the output is not stalled.
    vfcm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head_block),
        .head_pop   (head_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_vertex (vertex)
    );

    // Pack the vertex, first field in the lowest bits.
    assign m_tdata = {1'b0, vertex.index, vertex.ao, vertex.corner, vertex.face,
                      vertex.z, vertex.y, vertex.x};
    assign m_tlast = vertex.last;

endmodule

// ----- src/vfcm_front.sv -----
// ----------------------------------------------------------------------------
// vfcm_front
// Accepts block requests, builds the visible-face mask and drops requests
// that produce no vertex and carry no counter clear.
// ----------------------------------------------------------------------------
module vfcm_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_chunk_start,
    input  logic                             in_air,
    input  logic [vfcm_pkg::COORD_W-1:0]     in_x,
    input  logic [vfcm_pkg::COORD_W-1:0]     in_y,
    input  logic [vfcm_pkg::COORD_W-1:0]     in_z,
    input  logic [vfcm_pkg::NB_W-1:0]        in_nb,
    output logic                             push_valid,
    input  logic                             push_ready,
    output vfcm_pkg::block_t                 push_block
);

    logic                          valid_reg;
    logic                          valid_next;
    vfcm_pkg::block_t              block_reg;
    logic [vfcm_pkg::NUM_FACES-1:0] mask;
    logic                          keep;
    logic                          drain;

    always_comb begin
        for (int f = 0; f < vfcm_pkg::NUM_FACES; f++) begin
            mask[f] = !in_air && in_nb[vfcm_pkg::FACE_BIT[f]];
        end
    end

    // Fully hidden or air blocks without a clear have nothing to do downstream.
    assign keep       = (|block_reg.face_mask) || block_reg.chunk_start;
    assign push_valid = valid_reg && keep;
    assign drain      = !keep || push_ready;
    assign in_ready   = !valid_reg || drain;
    assign push_block = block_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            block_reg.chunk_start <= in_chunk_start;
            block_reg.x           <= in_x;
            block_reg.y           <= in_y;
            block_reg.z           <= in_z;
            block_reg.nb          <= in_nb;
            block_reg.face_mask   <= mask;
        end
    end

endmodule

// ----- src/vfcm_queue.sv -----
// ----------------------------------------------------------------------------
// vfcm_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module vfcm_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  vfcm_pkg::block_t wr_block,
    output logic             rd_valid,
    input  logic             rd_pop,
    output vfcm_pkg::block_t rd_block
);

    localparam int PTR_W = $clog2(vfcm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(vfcm_pkg::QUEUE_DEPTH + 1);

    vfcm_pkg::block_t   slot_reg [0:vfcm_pkg::QUEUE_DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign wr_ready = (count_reg != CNT_W'(vfcm_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_block = slot_reg[rd_ptr_reg];
    assign do_push  = wr_valid && wr_ready;
    assign do_pop   = rd_pop && rd_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wr_block;
        end
    end

endmodule

// ----- src/vfcm_back.sv -----
// ----------------------------------------------------------------------------
// vfcm_back
// Walks the visible faces of the head request, one vertex per cycle unless the
// output stalls, and owns the running vertex counter and the output register.
// ----------------------------------------------------------------------------
module vfcm_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  vfcm_pkg::block_t  head,
    output logic              head_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output vfcm_pkg::vertex_t out_vertex
);

    logic [vfcm_pkg::NUM_FACES-1:0] done_mask_reg;
    logic [vfcm_pkg::NUM_FACES-1:0] done_mask_next;
    logic [vfcm_pkg::CORNER_W-1:0]  corner_reg;
    logic [vfcm_pkg::CORNER_W-1:0]  corner_next;
    logic                           first_reg;
    logic                           first_next;
    logic [vfcm_pkg::COUNT_W-1:0]   count_reg;
    logic [vfcm_pkg::COUNT_W-1:0]   count_next;
    logic                           valid_reg;
    logic                           valid_next;
    vfcm_pkg::vertex_t              vertex_reg;

    logic [vfcm_pkg::NUM_FACES-1:0] remaining;
    logic [vfcm_pkg::NUM_FACES-1:0] face_hot;
    logic [vfcm_pkg::FACE_W-1:0]    face_sel;
    logic [2:0]                     pos;
    logic [vfcm_pkg::AO_W-1:0]      ao;
    logic [vfcm_pkg::COUNT_W-1:0]   index;
    logic                           out_free;
    logic                           emit;
    logic                           last;
    vfcm_pkg::vertex_t              vertex;

    assign remaining = head.face_mask & ~done_mask_reg;
    assign out_free  = !valid_reg || out_ready;
    assign emit      = head_valid && out_free && (|remaining);

    // Lowest pending face goes first.
    always_comb begin
        face_sel = '0;
        for (int f = vfcm_pkg::NUM_FACES - 1; f >= 0; f--) begin
            if (remaining[f]) begin
                face_sel = vfcm_pkg::FACE_W'(f);
            end
        end
    end

    assign face_hot = vfcm_pkg::NUM_FACES'(1) << face_sel;
    assign pos      = vfcm_pkg::CORNER_POS[face_sel][corner_reg];
    assign ao = vfcm_pkg::AO_W'({1'b0, head.nb[vfcm_pkg::AO_BIT[face_sel][corner_reg][0]]})
              + vfcm_pkg::AO_W'({1'b0, head.nb[vfcm_pkg::AO_BIT[face_sel][corner_reg][1]]})
              + vfcm_pkg::AO_W'({1'b0, head.nb[vfcm_pkg::AO_BIT[face_sel][corner_reg][2]]});
    assign index = (first_reg && head.chunk_start) ? '0 : count_reg;
    assign last  = (corner_reg == vfcm_pkg::LAST_CORNER) && ((remaining & ~face_hot) == '0);

    always_comb begin
        vertex.x      = head.x + vfcm_pkg::COORD_W'(pos[0]) - vfcm_pkg::COORD_W'(1);
        vertex.y      = head.y + vfcm_pkg::COORD_W'(pos[1]) - vfcm_pkg::COORD_W'(1);
        vertex.z      = head.z + vfcm_pkg::COORD_W'(pos[2]) - vfcm_pkg::COORD_W'(1);
        vertex.face   = face_sel;
        vertex.corner = corner_reg;
        vertex.ao     = ao;
        vertex.index  = index;
        vertex.last   = last;
    end

    always_comb begin
        done_mask_next = done_mask_reg;
        corner_next    = corner_reg;
        first_next     = first_reg;
        count_next     = count_reg;
        head_pop       = 1'b0;
        valid_next     = valid_reg;
        if (out_free) begin
            valid_next = emit;
        end
        if (head_valid && out_free) begin
            if (!(|remaining)) begin
                // Clear-only request: reset the counter and retire it.
                head_pop   = 1'b1;
                count_next = '0;
                first_next = 1'b1;
            end else begin
                count_next  = index + vfcm_pkg::COUNT_W'(1);
                corner_next = corner_reg + vfcm_pkg::CORNER_W'(1);
                first_next  = 1'b0;
                if (corner_reg == vfcm_pkg::LAST_CORNER) begin
                    done_mask_next = done_mask_reg | face_hot;
                end
                if (last) begin
                    head_pop       = 1'b1;
                    done_mask_next = '0;
                    first_next     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_mask_reg <= '0;
            corner_reg    <= '0;
            first_reg     <= 1'b1;
            count_reg     <= '0;
            valid_reg     <= 1'b0;
        end else begin
            done_mask_reg <= done_mask_next;
            corner_reg    <= corner_next;
            first_reg     <= first_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            vertex_reg <= vertex;
        end
    end

    assign out_valid  = valid_reg;
    assign out_vertex = vertex_reg;

endmodule

// ----- src/vfcm_checker.sv -----
// ----------------------------------------------------------------------------
// vfcm_checker
// Port-level checks on the mesher's vertex stream.
// ----------------------------------------------------------------------------
module vfcm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled vertex.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled vertex changed");

    // Face code stays within the six faces.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[17:15] != 3'd6 && m_tdata[17:15] != 3'd7)
        else $error("face code out of range");

    // A block always ends on the final corner of a face.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[19:18] == 2'd3)
        else $error("block ended mid-face");

    // Within a block, the next vertex advances index and corner by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            !m_tvalid ||
            (m_tdata[38:22] == 17'($past(m_tdata[38:22]) + 17'd1) &&
             m_tdata[19:18] == 2'($past(m_tdata[19:18]) + 2'd1)))
        else $error("vertex sequence broken inside block");

endmodule

bind voxel_face_cull_ao_mesher vfcm_checker u_vfcm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
